// File: design/scl_pkg.sv
// Shared types, codes and rule helpers for the subnet connection limiter.
// Used by the top level; no dependencies.
package scl_pkg;

  localparam int PEER_ENTRIES_DEF   = 64;
  localparam int SUBNET_ENTRIES_DEF = 64;
  localparam int RULE_SLOTS_DEF     = 4;
  localparam int COUNT_BITS_DEF     = 32;

  localparam int CFG_REGS     = 4;
  localparam int CFG_IDX_BITS = 3;
  localparam int RULE_BITS    = 42;
  localparam int MAX_BITS     = 32;
  localparam int PFX_BITS     = 8;
  localparam int V4_BITS      = 32;
  localparam int V6_BITS      = 128;

  localparam logic [2:0] OP_ADD            = 3'd0;
  localparam logic [2:0] OP_REMOVE         = 3'd1;
  localparam logic [2:0] OP_QUERY_ACCEPT   = 3'd2;
  localparam logic [2:0] OP_QUERY_OVERFLOW = 3'd3;
  localparam logic [2:0] OP_CLEAR          = 3'd4;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_LIMIT   = 3'd1;
  localparam logic [2:0] ST_UNKNOWN = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_INCONS  = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE, S_PSCAN, S_SLOT, S_SSCAN, S_DECIDE, S_PEERW, S_CSLOT, S_ALLOC, S_DONE
  } state_t;

  function automatic logic [PFX_BITS-1:0] rule_pfx(input logic [RULE_BITS-1:0] r);
    return r[9:2];
  endfunction

  function automatic logic [MAX_BITS-1:0] rule_max(input logic [RULE_BITS-1:0] r);
    return r[41:10];
  endfunction

  function automatic logic rule_active(input logic [RULE_BITS-1:0] r, input logic fam);
    logic [8:0] lim;
    lim = fam ? 9'(V6_BITS) : 9'(V4_BITS);
    return r[0] && (r[1] == fam) && ({1'b0, r[9:2]} <= lim);
  endfunction

  // bit b survives when it lies within the top p bits of the address
  function automatic logic [V6_BITS-1:0] pfx_mask(input logic fam,
                                                 input logic [PFX_BITS-1:0] p);
    logic [V6_BITS-1:0] m;
    m = '0;
    for (int b = 0; b < V6_BITS; b++) begin
      if (fam) begin
        m[b] = (9'(b) + {1'b0, p}) >= 9'(V6_BITS);
      end else if (b < V4_BITS) begin
        m[b] = (9'(b) + {1'b0, p}) >= 9'(V4_BITS);
      end
    end
    return m;
  endfunction

endpackage

// File: design/scl_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module scl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: design/subnet_connection_limiter_unit.sv
// Subnet connection limiter: top level, sequencer and table valid bits.
// Depends on scl_pkg and scl_ram (peer and subnet tables).
//
// Admission control for IPv4/IPv6 peers against up to RULE_SLOTS prefix rules.
// One item is in flight at a time; in_stall is high from acceptance until the
// result is loaded into the output register. The sequencer walks the peer
// table and then the subnet table once per active rule of the item's family,
// one entry a cycle through the registered RAM read ports; an add that
// creates new subnets also walks the subnet table for free entries. Clear
// and unused opcodes skip the table walks. Valid bits live in flops, so
// reset and clear take effect at once; there is no clearing pass. Rule writes
// are taken only while the block is idle (cfg_ready is low otherwise), and the
// input stalls while a rule write is offered.
module subnet_connection_limiter_unit
  import scl_pkg::*;
#(
  parameter int PEER_ENTRIES   = PEER_ENTRIES_DEF,
  parameter int SUBNET_ENTRIES = SUBNET_ENTRIES_DEF,
  parameter int RULE_SLOTS     = RULE_SLOTS_DEF,
  parameter int COUNT_BITS     = COUNT_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [2:0]              opcode,
  input  logic                    family,
  input  logic [63:0]             address_high,
  input  logic [63:0]             address_low,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    answer,
  output logic [2:0]              status,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [RULE_BITS-1:0]    cfg_data
);

  localparam int PIW = $clog2(PEER_ENTRIES);
  localparam int SIW = $clog2(SUBNET_ENTRIES);
  localparam int CW  = ((PIW > SIW) ? PIW : SIW) + 1;
  localparam int SLW = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
  localparam int PW  = V6_BITS + COUNT_BITS;

  // rule registers and latched item
  logic [RULE_BITS-1:0] rule [RULE_SLOTS];
  logic [2:0]           op;
  logic                 fam;
  logic [63:0]          ahi, alo;

  // table valid bits
  logic [PEER_ENTRIES-1:0]   peer_valid, peer_fam;
  logic [SUBNET_ENTRIES-1:0] sub_valid;
  logic [SLW-1:0]            sub_slot [SUBNET_ENTRIES];

  // sequencer
  state_t         state, state_next;
  logic [CW-1:0]  scan_cnt;
  logic [SLW:0]   slot;
  logic [SLW-1:0] sl;
  logic [SIW-1:0] fp;

  // search results
  logic                  p_hit, pf_found;
  logic [PIW-1:0]        p_idx, pf_idx;
  logic [COUNT_BITS-1:0] p_cnt;
  logic [RULE_SLOTS-1:0] s_hit;
  logic [SIW-1:0]        s_idx [RULE_SLOTS];
  logic [COUNT_BITS-1:0] s_cnt [RULE_SLOTS];
  logic [SIW:0]          free_cnt;
  logic                  r_ans;
  logic [2:0]            r_st;

  // RAM ports
  logic           p_we, s_we;
  logic [PIW-1:0] p_waddr;
  logic [SIW-1:0] s_waddr;
  logic [PW-1:0]  p_wdata, s_wdata, p_rdata, s_rdata;

  // comb helpers
  logic                  acc, scan_end_p, scan_end_s, cur_act, out_free;
  logic [CW-1:0]         cmp_cnt;
  logic [PIW-1:0]        kp;
  logic [SIW-1:0]        ks;
  logic [RULE_BITS-1:0]  cur_rule;
  logic [V6_BITS-1:0]    key;
  logic                  p_match, s_match;
  logic [2:0]            add_st, rm_st;
  logic                  ov;

  assign acc        = in_valid && !in_stall;
  // a pending rule write goes first, so item and rule write never share an edge
  assign in_stall   = (state != S_IDLE) || cfg_valid;
  assign cfg_ready  = (state == S_IDLE);
  assign out_free   = !out_valid || !out_stall;
  assign sl         = slot[SLW-1:0];
  assign cur_rule   = rule[sl];
  assign cur_act    = rule_active(cur_rule, fam);
  assign key        = pfx_mask(fam, rule_pfx(cur_rule)) & {ahi, alo};
  assign cmp_cnt    = scan_cnt - CW'(1);
  assign kp         = cmp_cnt[PIW-1:0];
  assign ks         = cmp_cnt[SIW-1:0];
  assign scan_end_p = (scan_cnt == CW'(PEER_ENTRIES));
  assign scan_end_s = (scan_cnt == CW'(SUBNET_ENTRIES));

  // compare stage: entry scan_cnt-1, whose data was read last cycle
  assign p_match = peer_valid[kp] && (peer_fam[kp] == fam) &&
                   (p_rdata[PW-1:COUNT_BITS] == {ahi, alo});
  assign s_match = sub_valid[ks] && (sub_slot[ks] == sl) &&
                   (s_rdata[PW-1:COUNT_BITS] == key);

  scl_ram #(.WIDTH(PW), .DEPTH(PEER_ENTRIES)) u_peer_ram (
    .clk     (clk),
    .wr_en   (p_we),
    .wr_addr (p_waddr),
    .wr_data (p_wdata),
    .rd_addr (scan_cnt[PIW-1:0]),
    .rd_data (p_rdata)
  );

  scl_ram #(.WIDTH(PW), .DEPTH(SUBNET_ENTRIES)) u_sub_ram (
    .clk     (clk),
    .wr_en   (s_we),
    .wr_addr (s_waddr),
    .wr_data (s_wdata),
    .rd_addr (scan_cnt[SIW-1:0]),
    .rd_data (s_rdata)
  );

  // verdicts from the collected search results
  always_comb begin
    logic          lim1;
    logic [SLW:0]  needed;
    logic [MAX_BITS-1:0] mx, c32;
    logic          act;
    lim1   = 1'b0;
    needed = '0;
    ov     = 1'b0;
    rm_st  = ST_OK;
    for (int s = 0; s < RULE_SLOTS; s++) begin
      act = rule_active(rule[s], fam);
      mx  = rule_max(rule[s]);
      c32 = MAX_BITS'(s_cnt[s]);
      if (act) begin
        if (s_hit[s]) begin
          if (c32 >= mx || (&s_cnt[s])) lim1 = 1'b1;
          if (c32 > mx) ov = 1'b1;
          if (rm_st == ST_OK && s_cnt[s] == '0) rm_st = ST_INCONS;
        end else begin
          if (mx == '0) lim1 = 1'b1;
          needed = needed + (SLW+1)'(1);
          if (rm_st == ST_OK) rm_st = ST_UNKNOWN;
        end
      end
    end
    if (lim1 || (p_hit && (&p_cnt))) begin
      add_st = ST_LIMIT;
    end else if (!p_hit && !pf_found) begin
      add_st = ST_FULL;
    end else if (32'(needed) > 32'(free_cnt)) begin
      add_st = ST_FULL;
    end else begin
      add_st = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and table write strobes
  always_comb begin
    state_next = state;
    p_we    = 1'b0;
    p_waddr = p_hit ? p_idx : pf_idx;
    p_wdata = {ahi, alo, p_hit ? (p_cnt + COUNT_BITS'(1)) : COUNT_BITS'(1)};
    s_we    = 1'b0;
    s_waddr = s_idx[sl];
    s_wdata = {key, s_cnt[sl] + COUNT_BITS'(1)};
    unique case (state)
      S_IDLE: begin
        if (acc) begin
          if (opcode >= OP_CLEAR) state_next = S_DONE;
          else state_next = S_PSCAN;
        end
      end
      S_PSCAN: begin
        if (scan_end_p) state_next = S_SLOT;
      end
      S_SLOT: begin
        if (slot == (SLW+1)'(RULE_SLOTS)) state_next = S_DECIDE;
        else if (cur_act) state_next = S_SSCAN;
      end
      S_SSCAN: begin
        if (scan_end_s) state_next = S_SLOT;
      end
      S_DECIDE: begin
        if ((op == OP_ADD && add_st == ST_OK) || (op == OP_REMOVE && p_hit)) begin
          state_next = S_PEERW;
        end else begin
          state_next = S_DONE;
        end
      end
      S_PEERW: begin
        p_we = 1'b1;
        if (op == OP_REMOVE) begin
          p_waddr = p_idx;
          p_wdata = {ahi, alo, (p_cnt != '0) ? (p_cnt - COUNT_BITS'(1)) : p_cnt};
        end
        state_next = S_CSLOT;
      end
      S_CSLOT: begin
        if (slot == (SLW+1)'(RULE_SLOTS)) begin
          state_next = S_DONE;
        end else if (cur_act) begin
          if (op == OP_ADD) begin
            if (s_hit[sl]) s_we = 1'b1;
            else state_next = S_ALLOC;
          end else if (s_hit[sl] && s_cnt[sl] != '0) begin
            s_we    = 1'b1;
            s_wdata = {key, s_cnt[sl] - COUNT_BITS'(1)};
          end
        end
      end
      S_ALLOC: begin
        s_waddr = fp;
        s_wdata = {key, COUNT_BITS'(1)};
        if (!sub_valid[fp]) begin
          s_we       = 1'b1;
          state_next = S_CSLOT;
        end
      end
      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control registers: valid bits, rules, output register
  always_ff @(posedge clk) begin
    if (rst) begin
      peer_valid <= '0;
      sub_valid  <= '0;
      out_valid  <= 1'b0;
      for (int s = 0; s < RULE_SLOTS; s++) rule[s] <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        for (int s = 0; s < RULE_SLOTS; s++) begin
          if (s < CFG_REGS && cfg_index == CFG_IDX_BITS'(s)) rule[s] <= cfg_data;
        end
        // a rewritten rule drops all of its subnets
        for (int i = 0; i < SUBNET_ENTRIES; i++) begin
          if (32'(cfg_index) < RULE_SLOTS && 32'(cfg_index) < CFG_REGS &&
              CFG_IDX_BITS'(sub_slot[i]) == cfg_index) begin
            sub_valid[i] <= 1'b0;
          end
        end
      end else if (acc && opcode == OP_CLEAR) begin
        peer_valid <= '0;
        sub_valid  <= '0;
      end
      if (state == S_PEERW) begin
        if (op == OP_ADD) begin
          peer_valid[p_waddr] <= 1'b1;
          peer_fam[p_waddr]   <= fam;
        end else if (p_cnt <= COUNT_BITS'(1)) begin
          peer_valid[p_idx] <= 1'b0;
        end
      end
      if (state == S_CSLOT && slot != (SLW+1)'(RULE_SLOTS) && cur_act &&
          op == OP_REMOVE && s_hit[sl] && s_cnt[sl] == COUNT_BITS'(1)) begin
        sub_valid[s_idx[sl]] <= 1'b0;
      end
      if (state == S_ALLOC && !sub_valid[fp]) sub_valid[fp] <= 1'b1;
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // sequencer datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      slot     <= '0;
      scan_cnt <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (acc) begin
            op       <= opcode;
            fam      <= family;
            ahi      <= family ? address_high : 64'd0;
            alo      <= family ? address_low : {32'd0, address_low[31:0]};
            scan_cnt <= '0;
            slot     <= '0;
            p_hit    <= 1'b0;
            pf_found <= 1'b0;
            r_ans    <= (opcode == OP_CLEAR);
            r_st     <= ST_OK;
          end
        end
        S_PSCAN: begin
          scan_cnt <= scan_cnt + CW'(1);
          if (scan_cnt != '0) begin
            if (p_match) begin
              p_hit <= 1'b1;
              p_idx <= kp;
              p_cnt <= p_rdata[COUNT_BITS-1:0];
            end
            if (!peer_valid[kp] && !pf_found) begin
              pf_found <= 1'b1;
              pf_idx   <= kp;
            end
          end
        end
        S_SLOT: begin
          if (slot != (SLW+1)'(RULE_SLOTS)) begin
            s_hit[sl] <= 1'b0;
            scan_cnt  <= '0;
            // free count comes from the last scan, so only a scan restarts it
            if (!cur_act) slot <= slot + (SLW+1)'(1);
            else free_cnt <= '0;
          end
        end
        S_SSCAN: begin
          scan_cnt <= scan_cnt + CW'(1);
          if (scan_cnt != '0) begin
            if (s_match) begin
              s_hit[sl] <= 1'b1;
              s_idx[sl] <= ks;
              s_cnt[sl] <= s_rdata[COUNT_BITS-1:0];
            end
            if (!sub_valid[ks]) free_cnt <= free_cnt + (SIW+1)'(1);
          end
          if (scan_end_s) slot <= slot + (SLW+1)'(1);
        end
        S_DECIDE: begin
          case (op)
            OP_ADD, OP_QUERY_ACCEPT: begin
              r_ans <= (add_st == ST_OK);
              r_st  <= add_st;
            end
            OP_REMOVE: begin
              r_ans <= p_hit && (rm_st == ST_OK);
              r_st  <= p_hit ? rm_st : ST_UNKNOWN;
            end
            default: begin
              r_ans <= ov;
              r_st  <= ST_OK;
            end
          endcase
        end
        S_PEERW: begin
          slot <= '0;
          fp   <= '0;
        end
        S_CSLOT: begin
          if (slot != (SLW+1)'(RULE_SLOTS) &&
              !(cur_act && op == OP_ADD && !s_hit[sl])) begin
            slot <= slot + (SLW+1)'(1);
          end
        end
        S_ALLOC: begin
          fp <= fp + SIW'(1);
          if (!sub_valid[fp]) begin
            sub_slot[fp] <= sl;
            slot         <= slot + (SLW+1)'(1);
          end
        end
        S_DONE: begin
          if (out_free) begin
            answer <= r_ans;
            status <= r_st;
          end
        end
        default: ;
      endcase
    end
  end

  // a successful item always reports ok
  a_ans_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && answer |-> status == ST_OK)
    else $error("answer set with nonzero status");

  // clear empties both tables at once
  a_clear: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && opcode == OP_CLEAR |=> peer_valid == '0 && sub_valid == '0)
    else $error("tables not empty after clear");

  // a finished result holds while the output register is occupied
  a_done_hold: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE && out_valid && out_stall |=> state == S_DONE)
    else $error("result dropped while output busy");

endmodule
